// ===== hw/rtl/cbss_pkg.sv =====
// Shared types and constants of the credit-based shaper scheduler.
package cbss_pkg;

  localparam int TASK_W     = 16;
  localparam int PRIO_W     = 8;
  localparam int LEVEL_W    = 9;
  localparam int BW_W       = 17;
  localparam int CREDIT_W   = 64;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_SHAPED = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BW_A    = 3'd3;

  localparam logic [LEVEL_W-1:0] LEVEL_BEST_EFFORT = 9'd256;
  localparam logic [BW_W-1:0]    BW_ONE            = 17'd65536;
  localparam logic [BW_W-1:0]    BW_RESET          = 17'd16384;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ASSIGNED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

  localparam logic FUNC_ENQUEUE = 1'b0;
  localparam logic FUNC_DECIDE  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ENQ_WR,
    ST_BUDGET,
    ST_MUL,
    ST_UPD,
    ST_RD,
    ST_RD_DAT,
    ST_WCHK,
    ST_DIV,
    ST_DIV_END,
    ST_DONE
  } cbss_state_e;

endpackage

// ===== hw/rtl/credit_based_shaper_scheduler_core.sv =====
// Credit-based shaper scheduler: class queues, credit update and wait search.
// Enqueue: a scan of all classes, then the queue write; one item at a time.
// Decide (busy): credit update of every class in the shared multiply/credit unit.
// Decide (not busy): credit update, then a scan; a found class is read from its queue,
// else the bit-serial divider computes a wait for each non-empty class.
// Reset (async, active low) clears credits and queues; levels and bandwidths return to defaults.
module credit_based_shaper_scheduler_core #(
  parameter int NUM_CLASSES = 4,
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 48
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // task_id, priority_req, time_now, busy_req
  input  logic [((TIME_BITS+25+7)/8)*8-1:0] s_tdata,
  // func
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // status, assigned_task, wait_time, wait_valid
  output logic [((TIME_BITS+19+7)/8)*8-1:0] m_tdata,
  input  logic                              cfg_we_i,
  input  logic [cbss_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [cbss_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int NC    = NUM_CLASSES;
  localparam int BE    = NC - 1;
  localparam int KW    = $clog2(NC);
  localparam int AC_W  = $clog2(NC + 1);
  localparam int HW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int AW    = $clog2(NC * QUEUE_DEPTH);
  localparam int PW    = TIME_BITS + cbss_pkg::BW_W;
  localparam int XW    = (PW > 64) ? PW : 64;
  localparam int OUT_W = ((TIME_BITS + 19 + 7) / 8) * 8;
  localparam int CRW   = cbss_pkg::CREDIT_W;
  localparam logic [63:0] TMASK64 =
    (TIME_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << TIME_BITS) - 64'd1);

  cbss_pkg::cbss_state_e state_q, state_d;

  logic [cbss_pkg::LEVEL_W-1:0] level_q [NC];
  logic [cbss_pkg::BW_W-1:0]    bw_q    [NC];
  logic [CRW-1:0]               credit_q [NC];
  logic                         we_q    [NC];
  logic [HW-1:0]                head_q  [NC];
  logic [CW-1:0]                cnt_q   [NC];
  logic [AC_W-1:0]              active_q;
  logic [TIME_BITS-1:0]         last_q;
  logic                         first_q;

  logic                         func_q, busy_q;
  logic [cbss_pkg::TASK_W-1:0]  task_q;
  logic [cbss_pkg::PRIO_W-1:0]  prio_q;
  logic [TIME_BITS-1:0]         now_q, budget_q;
  logic [KW-1:0]                k_q, best_k_q;
  logic [cbss_pkg::LEVEL_W-1:0] best_lvl_q, act_lvl_q;
  logic                         found_q, act_v_q;
  logic [62:0]                  m_q;
  logic [63:0]                  dq_q;
  logic [cbss_pkg::BW_W-1:0]    rem_q;
  logic [5:0]                   div_cnt_q;
  logic                         any_q;

  logic [cbss_pkg::STATUS_W-1:0] res_status_q, out_status_q;
  logic [cbss_pkg::TASK_W-1:0]   res_task_q, out_task_q;
  logic [TIME_BITS-1:0]          res_wait_q, out_wait_q;
  logic                          res_wv_q, out_wv_q, out_valid_q;

  logic [cbss_pkg::TASK_W-1:0] rd_data;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr, ram_raddr;

  // class-level views at index k
  logic                         last_k, ne_k, full_k, act_k, elig, take;
  logic [KW-1:0]                lvl_idx, cand_k;
  logic [cbss_pkg::LEVEL_W-1:0] lvl_k;
  logic [cbss_pkg::BW_W-1:0]    bw_k, mult;
  logic [CRW-1:0]               c_k, c_n, nadd, nsub;
  logic                         we_n;
  logic [PW-1:0]                prod;
  logic [XW-1:0]                prod_x;
  logic [64:0]                  add_s, sub_s;
  logic [HW:0]                  slot_sum;
  logic [HW-1:0]                slot;
  logic [cbss_pkg::BW_W:0]      div_t;
  logic                         div_ge;
  logic [63:0]                  mag, w64;
  logic [TIME_BITS-1:0]         w;

  assign last_k  = (k_q == KW'(NC - 1));
  assign lvl_idx = (state_q == cbss_pkg::ST_BUDGET) ? active_q[KW-1:0] : k_q;
  assign lvl_k   = level_q[lvl_idx];
  assign c_k     = credit_q[k_q];
  assign ne_k    = (cnt_q[k_q] != '0);
  assign full_k  = (cnt_q[k_q] == CW'(QUEUE_DEPTH));
  assign act_k   = act_v_q && (lvl_k == act_lvl_q);

  always_comb begin
    bw_k = bw_q[k_q];
    if (bw_k == '0) begin
      bw_k = cbss_pkg::BW_W'(1);
    end else if (bw_k > cbss_pkg::BW_ONE) begin
      bw_k = cbss_pkg::BW_ONE;
    end
  end

  assign mult   = act_k ? (cbss_pkg::BW_ONE - bw_k) : bw_k;
  assign prod   = PW'(budget_q) * PW'(mult);
  assign prod_x = XW'(prod);

  assign add_s = {c_k[CRW-1], c_k} + {2'b00, m_q};
  assign sub_s = {c_k[CRW-1], c_k} - {2'b00, m_q};
  assign nadd  = (add_s[64:63] == 2'b01) ? {1'b0, {63{1'b1}}} : add_s[63:0];
  assign nsub  = (sub_s[64:63] == 2'b10) ? {1'b1, 63'd0} : sub_s[63:0];

  always_comb begin
    c_n  = c_k;
    we_n = we_q[k_q];
    if (busy_q) begin
      if (!act_k) begin
        if (ne_k) begin
          c_n = nadd;
          if (we_q[k_q]) begin
            if (!nadd[CRW-1]) c_n = '0;
            we_n = 1'b0;
          end
        end else if (c_k[CRW-1]) begin
          c_n = nadd[CRW-1] ? nadd : '0;
        end
      end else begin
        we_n = 1'b0;
        c_n  = nsub;
      end
    end else if (ne_k) begin
      if (!act_k) begin
        c_n = nadd;
        if (!nadd[CRW-1] && we_q[k_q]) begin
          we_n = 1'b0;
          c_n  = '0;
        end
      end else begin
        c_n = nsub;
      end
    end else begin
      c_n = act_k ? nsub : nadd;
      if (!c_n[CRW-1]) c_n = '0;
    end
  end

  assign elig   = (func_q == cbss_pkg::FUNC_ENQUEUE)
                  ? (lvl_k >= {1'b0, prio_q}) : (ne_k && !c_k[CRW-1]);
  assign take   = elig && (!found_q || (lvl_k < best_lvl_q));
  assign cand_k = take ? k_q : best_k_q;

  assign slot_sum = (HW+1)'(head_q[k_q]) + (HW+1)'(cnt_q[k_q]);
  assign slot     = (slot_sum >= (HW+1)'(QUEUE_DEPTH))
                    ? HW'(slot_sum - (HW+1)'(QUEUE_DEPTH)) : slot_sum[HW-1:0];

  assign div_t  = {rem_q, dq_q[63]};
  assign div_ge = (div_t >= {1'b0, bw_k});
  assign mag    = c_k[CRW-1] ? (~c_k + 64'd1) : 64'd0;
  assign w64    = (dq_q > TMASK64) ? TMASK64 : dq_q;
  assign w      = TIME_BITS'(w64);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cbss_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_d = (s_tuser == cbss_pkg::FUNC_DECIDE) ? cbss_pkg::ST_BUDGET
                                                        : cbss_pkg::ST_SCAN;
        end
      end
      cbss_pkg::ST_SCAN: begin
        if (last_k) begin
          if (func_q == cbss_pkg::FUNC_ENQUEUE) begin
            state_d = cbss_pkg::ST_ENQ_WR;
          end else begin
            state_d = (found_q || take) ? cbss_pkg::ST_RD : cbss_pkg::ST_WCHK;
          end
        end
      end
      cbss_pkg::ST_ENQ_WR:  state_d = cbss_pkg::ST_DONE;
      cbss_pkg::ST_BUDGET:  state_d = cbss_pkg::ST_MUL;
      cbss_pkg::ST_MUL:     state_d = cbss_pkg::ST_UPD;
      cbss_pkg::ST_UPD: begin
        if (!last_k) state_d = cbss_pkg::ST_MUL;
        else state_d = busy_q ? cbss_pkg::ST_DONE : cbss_pkg::ST_SCAN;
      end
      cbss_pkg::ST_RD:      state_d = cbss_pkg::ST_RD_DAT;
      cbss_pkg::ST_RD_DAT:  state_d = cbss_pkg::ST_DONE;
      cbss_pkg::ST_WCHK: begin
        if (ne_k) state_d = cbss_pkg::ST_DIV;
        else if (last_k) state_d = cbss_pkg::ST_DONE;
      end
      cbss_pkg::ST_DIV: begin
        if (div_cnt_q == 6'd63) state_d = cbss_pkg::ST_DIV_END;
      end
      cbss_pkg::ST_DIV_END: state_d = last_k ? cbss_pkg::ST_DONE : cbss_pkg::ST_WCHK;
      cbss_pkg::ST_DONE: begin
        if (!out_valid_q || m_tready) state_d = cbss_pkg::ST_IDLE;
      end
      default: state_d = cbss_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready  = (state_q == cbss_pkg::ST_IDLE);
    ram_we    = (state_q == cbss_pkg::ST_ENQ_WR) && !full_k;
    ram_waddr = AW'(k_q) * AW'(QUEUE_DEPTH) + AW'(slot);
    ram_raddr = AW'(k_q) * AW'(QUEUE_DEPTH) + AW'(head_q[k_q]);
  end

  cbss_ram #(
    .WIDTH(cbss_pkg::TASK_W),
    .DEPTH(NC * QUEUE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(task_q),
    .raddr_i(ram_raddr),
    .rdata_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cbss_pkg::ST_IDLE;
      active_q    <= AC_W'(NC);
      last_q      <= '0;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
      for (int j = 0; j < NC; j++) begin
        level_q[j]  <= (j == BE) ? cbss_pkg::LEVEL_BEST_EFFORT : cbss_pkg::LEVEL_W'(j + 1);
        bw_q[j]     <= (j == BE) ? cbss_pkg::BW_ONE : cbss_pkg::BW_RESET;
        credit_q[j] <= '0;
        we_q[j]     <= 1'b0;
        head_q[j]   <= '0;
        cnt_q[j]    <= '0;
      end
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        for (int j = 0; j < BE; j++) begin
          if (j < cbss_pkg::CFG_SHAPED) begin
            if (cfg_idx_i == cbss_pkg::CFG_LEVEL_A + cbss_pkg::CFG_IDX_W'(j)) begin
              level_q[j] <= {1'b0, cfg_data_i[7:0]};
            end
            if (cfg_idx_i == cbss_pkg::CFG_BW_A + cbss_pkg::CFG_IDX_W'(j)) begin
              bw_q[j] <= cfg_data_i;
            end
          end
        end
      end

      if (out_valid_q && m_tready && state_q != cbss_pkg::ST_DONE) out_valid_q <= 1'b0;

      unique case (state_q)
        cbss_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            func_q       <= s_tuser;
            task_q       <= s_tdata[15:0];
            prio_q       <= s_tdata[23:16];
            now_q        <= s_tdata[24 +: TIME_BITS];
            busy_q       <= s_tdata[24 + TIME_BITS];
            k_q          <= '0;
            found_q      <= 1'b0;
            any_q        <= 1'b0;
            res_status_q <= cbss_pkg::STATUS_OK;
            res_task_q   <= '0;
            res_wait_q   <= '0;
            res_wv_q     <= 1'b0;
          end
        end
        cbss_pkg::ST_SCAN: begin
          if (take) begin
            best_k_q   <= k_q;
            best_lvl_q <= lvl_k;
            found_q    <= 1'b1;
          end
          if (last_k && func_q == cbss_pkg::FUNC_DECIDE && !(found_q || take)) begin
            k_q      <= '0;
            active_q <= AC_W'(NC);
          end else begin
            k_q <= last_k ? cand_k : (k_q + KW'(1));
          end
        end
        cbss_pkg::ST_ENQ_WR: begin
          if (full_k) begin
            res_status_q <= cbss_pkg::STATUS_FULL;
          end else begin
            cnt_q[k_q] <= cnt_q[k_q] + CW'(1);
            if (!ne_k) we_q[k_q] <= 1'b1;
          end
        end
        cbss_pkg::ST_BUDGET: begin
          budget_q  <= first_q ? '0 : (now_q - last_q);
          last_q    <= now_q;
          first_q   <= 1'b0;
          act_lvl_q <= lvl_k;
          act_v_q   <= (active_q < AC_W'(NC));
          k_q       <= '0;
        end
        cbss_pkg::ST_MUL: begin
          m_q <= (|prod_x[XW-1:63]) ? {63{1'b1}} : prod_x[62:0];
        end
        cbss_pkg::ST_UPD: begin
          credit_q[k_q] <= c_n;
          we_q[k_q]     <= we_n;
          k_q           <= last_k ? '0 : (k_q + KW'(1));
        end
        cbss_pkg::ST_RD: begin
          head_q[k_q]  <= (head_q[k_q] == HW'(QUEUE_DEPTH - 1)) ? '0
                                                              : (head_q[k_q] + HW'(1));
          cnt_q[k_q]   <= cnt_q[k_q] - CW'(1);
          active_q     <= AC_W'(k_q);
          res_status_q <= cbss_pkg::STATUS_ASSIGNED;
        end
        cbss_pkg::ST_RD_DAT: begin
          res_task_q <= rd_data;
        end
        cbss_pkg::ST_WCHK: begin
          if (ne_k) begin
            dq_q      <= mag + 64'(bw_k) - 64'd1;
            rem_q     <= '0;
            div_cnt_q <= '0;
          end else if (!last_k) begin
            k_q <= k_q + KW'(1);
          end
        end
        cbss_pkg::ST_DIV: begin
          rem_q     <= div_ge ? cbss_pkg::BW_W'(div_t - {1'b0, bw_k})
                              : div_t[cbss_pkg::BW_W-1:0];
          dq_q      <= {dq_q[62:0], div_ge};
          div_cnt_q <= div_cnt_q + 6'd1;
        end
        cbss_pkg::ST_DIV_END: begin
          if (!any_q || w < res_wait_q) res_wait_q <= w;
          any_q    <= 1'b1;
          res_wv_q <= 1'b1;
          if (!last_k) k_q <= k_q + KW'(1);
        end
        cbss_pkg::ST_DONE: begin
          if (!out_valid_q || m_tready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_task_q   <= res_task_q;
            out_wait_q   <= res_wait_q;
            out_wv_q     <= res_wv_q;
          end
        end
        default: ;
      endcase
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = OUT_W'({out_wv_q, out_wait_q, out_task_q, out_status_q});

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second transfer taken while an item is in progress");

  a_assign_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == cbss_pkg::STATUS_ASSIGNED) |-> !out_wv_q)
    else $error("wait reported together with an assignment");

  a_wait_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_wv_q) |-> (out_wait_q == '0))
    else $error("wait time set without wait_valid");

  a_active_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q <= AC_W'(NC))
    else $error("active class out of range");

endmodule

// ===== hw/rtl/cbss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cbss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
